### hdl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// implication with the consequent checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/bmcs_pkg.sv
// shared types and constants for the baseline core step block
package bmcs_pkg;

  localparam int FileRegCount = 32;
  localparam int StackDepth   = 2;

  localparam logic [7:0] PclReset    = 8'hff;
  localparam logic [7:0] StatusReset = 8'h18;
  localparam logic [7:0] FsrReset    = 8'he0;
  localparam logic [7:0] OscReset    = 8'hfe;
  localparam logic [7:0] TrisReset   = 8'h3f;
  localparam logic [7:0] OptionReset = 8'hff;

  localparam logic [4:0] AddrIndf   = 5'd0;
  localparam logic [4:0] AddrPcl    = 5'd2;
  localparam logic [4:0] AddrStatus = 5'd3;
  localparam logic [4:0] AddrFsr    = 5'd4;
  localparam logic [4:0] AddrGpio   = 5'd6;

  typedef enum logic [1:0] {
    FAULT_NONE  = 2'd0,
    FAULT_UNSUP = 2'd1,
    FAULT_ILLEG = 2'd2
  } fault_t;

  typedef struct packed {
    logic [8:0] next_pc;
    logic       dead_cycle;
    logic [5:0] pins_out;
    logic [7:0] w_value;
    logic [7:0] status_value;
    logic       stream_bit_valid;
    logic       stream_bit;
    logic       stream_start;
    fault_t     fault;
  } result_t;

endpackage

### hdl/bmcs_if.sv
// valid/ready channel interfaces for instruction items and result items
interface bmcs_in_if;
  logic        valid;
  logic        ready;
  logic [11:0] opcode;
  logic [5:0]  pins_in;
  modport source (output valid, opcode, pins_in, input ready);
  modport sink   (input valid, opcode, pins_in, output ready);
endinterface

interface bmcs_out_if;
  logic       valid;
  logic       ready;
  logic [8:0] next_pc;
  logic       dead_cycle;
  logic [5:0] pins_out;
  logic [7:0] w_value;
  logic [7:0] status_value;
  logic       stream_bit_valid;
  logic       stream_bit;
  logic       stream_start;
  logic [1:0] fault;
  modport source (output valid, next_pc, dead_cycle, pins_out, w_value, status_value,
                  stream_bit_valid, stream_bit, stream_start, fault, input ready);
  modport sink   (input valid, next_pc, dead_cycle, pins_out, w_value, status_value,
                  stream_bit_valid, stream_bit, stream_start, fault, output ready);
endinterface

### hdl/baseline_mcu_core_step.sv
// baseline 8-bit microcontroller core, one instruction per item
// Each accepted item carries the 12-bit instruction fetched at the last reported
// next_pc (0x1ff after reset) plus the pin levels; the block executes it against
// W, 32 file registers in flops, TRIS, OPTION and a two-entry return stack, and
// loads one result item into the output register. A new item is taken every
// cycle while the output register is empty or being drained, so the rate is one
// item per clock. Faulting opcodes (SLEEP, CLRWDT, unrecognized) leave all
// state untouched and repeat the current PC with fault set.
module baseline_mcu_core_step #(
  parameter int FILE_REG_COUNT = bmcs_pkg::FileRegCount,
  parameter int STACK_DEPTH    = bmcs_pkg::StackDepth
) (
  input logic clk,
  input logic rst,
  bmcs_in_if.sink    in_ch,
  bmcs_out_if.source out_ch
);
  localparam int AW = $clog2(FILE_REG_COUNT);

  // architectural state
  logic [7:0] file_regs [FILE_REG_COUNT];
  logic [7:0] tris_reg;
  logic [7:0] option_reg;
  logic [7:0] w_reg;
  logic       pc_high;
  logic [8:0] return_stack [STACK_DEPTH];
  logic [7:0] pin_state;

  // output register
  logic                 out_valid;
  bmcs_pkg::result_t    res;
  bmcs_pkg::result_t    res_next;

  logic accept;
  assign in_ch.ready = !out_valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // decode
  logic [11:0] op;
  logic [AW-1:0] f, addr;
  logic d;
  logic [3:0] grp;
  bmcs_pkg::fault_t fault;
  assign op   = in_ch.opcode;
  assign f    = op[AW-1:0];
  assign d    = op[5];
  assign grp  = op[9:6];
  // indirect through fsr
  assign addr = (f == AW'(0)) ? file_regs[bmcs_pkg::AddrFsr[AW-1:0]][AW-1:0] : f;

  always_comb begin
    fault = bmcs_pkg::FAULT_NONE;
    if (op[11:5] == 7'd0) begin
      if (op[4:0] == 5'd3 || op[4:0] == 5'd4) fault = bmcs_pkg::FAULT_UNSUP;
      else if (op[4:0] == 5'd1 || op[4:0] > 5'd7) fault = bmcs_pkg::FAULT_ILLEG;
    end
  end

  // program counter, already advanced when an operand reads pcl
  logic [8:0] pc, pc_inc, pc_inc2, pc_new;
  assign pc      = {pc_high, file_regs[bmcs_pkg::AddrPcl[AW-1:0]]};
  assign pc_inc  = pc + 9'd1;
  assign pc_inc2 = pc + 9'd2;

  // operand read with gpio merge
  logic [7:0] m, latch;
  assign latch = file_regs[bmcs_pkg::AddrGpio[AW-1:0]];
  always_comb begin
    if (addr == AW'(0)) m = 8'h00;
    else if (addr == bmcs_pkg::AddrGpio[AW-1:0])
      m = 8'h08 | (latch & ~tris_reg & 8'h37)
        | ({2'b00, in_ch.pins_in} & tris_reg & 8'h33) | (tris_reg & 8'h04);
    else if (addr == bmcs_pkg::AddrPcl[AW-1:0]) m = pc_inc[7:0];
    else m = file_regs[addr];
  end

  logic [7:0] status, alu_r;
  logic c_out, c_upd, dc_out, dc_upd, z_upd;
  assign status = file_regs[bmcs_pkg::AddrStatus[AW-1:0]];

  bmcs_alu u_alu (
    .grp(grp), .m(m), .w(w_reg), .c_in(status[0]), .r(alu_r),
    .c_out(c_out), .c_upd(c_upd), .dc_out(dc_out), .dc_upd(dc_upd), .z_upd(z_upd)
  );

  // execute: compute next values of everything touched
  logic [7:0] w_new, st_new, tris_new, opt_new, r, mask, lit, wlit;
  logic wr_file, skip, dead, sv, ss;
  logic [8:0] stk0_new, stk1_new;

  assign lit     = op[7:0];
  assign mask    = 8'd1 << op[7:5];

  always_comb begin
    w_new = w_reg; st_new = status; tris_new = tris_reg; opt_new = option_reg;
    r = alu_r; wr_file = 1'b0; skip = 1'b0; dead = 1'b0; sv = 1'b0; ss = 1'b0;
    stk0_new = return_stack[0]; stk1_new = return_stack[1];
    pc_new = pc_inc; wlit = 8'h00;
    if (!op[11]) begin
      if (!op[10]) begin
        if (grp == 4'h0) begin
          if (d) wr_file = 1'b1;
          else if (op[4:0] == 5'd2) opt_new = w_reg;
          else if (op[4:0] == 5'd5) sv = 1'b1;
          else if (op[4:0] == 5'd6) tris_new = w_reg;
          else if (op[4:0] == 5'd7) ss = 1'b1;
        end else begin
          if (d) wr_file = 1'b1;
          else w_new = alu_r;
          if (c_upd) st_new[0] = c_out;
          if (dc_upd) st_new[1] = dc_out;
          if (z_upd) st_new[2] = (alu_r == 8'h00);
          if (grp == 4'hb || grp == 4'hf) skip = (alu_r == 8'h00);
        end
      end else begin
        case (op[9:8])
          2'd0: begin r = m & ~mask; wr_file = 1'b1; end
          2'd1: begin r = m | mask; wr_file = 1'b1; end
          2'd2: skip = ((m & mask) == 8'h00);
          default: skip = ((m & mask) != 8'h00);
        endcase
      end
    end else begin
      case (op[11:8])
        4'h8: begin
          dead = 1'b1; pc_new = return_stack[0]; stk0_new = return_stack[1];
          w_new = lit;
        end
        4'h9: begin
          dead = 1'b1; stk1_new = return_stack[0]; stk0_new = pc_inc;
          pc_new = {1'b0, lit};
        end
        4'ha, 4'hb: begin dead = 1'b1; pc_new = {op[8], lit}; end
        4'hc: w_new = lit;
        4'hd: begin wlit = w_reg | lit; w_new = wlit; st_new[2] = (wlit == 8'h00); end
        4'he: begin wlit = w_reg & lit; w_new = wlit; st_new[2] = (wlit == 8'h00); end
        default: begin
          wlit = w_reg ^ lit; w_new = wlit; st_new[2] = (wlit == 8'h00);
        end
      endcase
    end
    if (skip) begin
      pc_new = pc_inc2; dead = 1'b1;
    end
    // indirect through fsr pointing at zero drops the write
    if (addr == AW'(0)) wr_file = 1'b0;
  end

  // final state values after the file write
  logic [7:0] gpio_fin, st_fin;
  logic [8:0] pc_fin;
  assign st_fin   = (wr_file && addr == bmcs_pkg::AddrStatus[AW-1:0]) ? r : st_new;
  assign pc_fin   = (wr_file && addr == bmcs_pkg::AddrPcl[AW-1:0]) ? {1'b0, r} : pc_new;
  assign gpio_fin = (wr_file && addr == bmcs_pkg::AddrGpio[AW-1:0]) ? r : latch;

  logic [7:0] pin_fin;
  assign pin_fin = (wr_file && addr == bmcs_pkg::AddrGpio[AW-1:0]) ? (r | tris_new)
                 : (tris_new != tris_reg || (grp == 4'h0 && !d && op[4:0] == 5'd6
                    && !op[11] && !op[10])) ? (latch | tris_new) : pin_state;

  always_comb begin
    res_next.next_pc          = (fault == bmcs_pkg::FAULT_NONE) ? pc_fin : pc;
    res_next.dead_cycle       = (fault == bmcs_pkg::FAULT_NONE) && dead;
    res_next.pins_out         = (fault == bmcs_pkg::FAULT_NONE) ? pin_fin[5:0]
                                                                : pin_state[5:0];
    res_next.w_value          = (fault == bmcs_pkg::FAULT_NONE) ? w_new : w_reg;
    res_next.status_value     = (fault == bmcs_pkg::FAULT_NONE) ? st_fin : status;
    res_next.stream_bit_valid = (fault == bmcs_pkg::FAULT_NONE) && sv;
    res_next.stream_bit       = (fault == bmcs_pkg::FAULT_NONE) && sv && w_reg[0];
    res_next.stream_start     = (fault == bmcs_pkg::FAULT_NONE) && ss;
    res_next.fault            = fault;
  end

  // state update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < FILE_REG_COUNT; i++) begin
        if (AW'(i) == bmcs_pkg::AddrPcl[AW-1:0]) file_regs[i] <= bmcs_pkg::PclReset;
        else if (AW'(i) == bmcs_pkg::AddrStatus[AW-1:0])
          file_regs[i] <= bmcs_pkg::StatusReset;
        else if (AW'(i) == bmcs_pkg::AddrFsr[AW-1:0]) file_regs[i] <= bmcs_pkg::FsrReset;
        else if (AW'(i) == AW'(5)) file_regs[i] <= bmcs_pkg::OscReset;
        else file_regs[i] <= 8'h00;
      end
      tris_reg   <= bmcs_pkg::TrisReset;
      option_reg <= bmcs_pkg::OptionReset;
      w_reg      <= 8'h00;
      pc_high    <= 1'b1;
      for (int i = 0; i < STACK_DEPTH; i++) return_stack[i] <= 9'h000;
      pin_state  <= bmcs_pkg::TrisReset;
    end else if (accept && fault == bmcs_pkg::FAULT_NONE) begin
      // status flags, pc and gpio resolved with the file write already applied
      for (int i = 0; i < FILE_REG_COUNT; i++) begin
        if (AW'(i) == bmcs_pkg::AddrStatus[AW-1:0]) file_regs[i] <= st_fin;
        else if (AW'(i) == bmcs_pkg::AddrPcl[AW-1:0]) file_regs[i] <= pc_fin[7:0];
        else if (AW'(i) == bmcs_pkg::AddrGpio[AW-1:0]) file_regs[i] <= gpio_fin;
        else if (wr_file && addr == AW'(i)) file_regs[i] <= r;
      end
      pc_high    <= pc_fin[8];
      w_reg      <= w_new;
      tris_reg   <= tris_new;
      option_reg <= opt_new;
      pin_state  <= pin_fin;
      return_stack[0] <= stk0_new;
      return_stack[1] <= stk1_new;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (accept) out_valid <= 1'b1;
    else if (out_ch.ready) out_valid <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (accept) res <= res_next;
  end

  assign out_ch.valid            = out_valid;
  assign out_ch.next_pc          = res.next_pc;
  assign out_ch.dead_cycle       = res.dead_cycle;
  assign out_ch.pins_out         = res.pins_out;
  assign out_ch.w_value          = res.w_value;
  assign out_ch.status_value     = res.status_value;
  assign out_ch.stream_bit_valid = res.stream_bit_valid;
  assign out_ch.stream_bit       = res.stream_bit;
  assign out_ch.stream_start     = res.stream_start;
  assign out_ch.fault            = res.fault;
endmodule

### hdl/bmcs_alu.sv
// alu for the byte-oriented file instructions: result, carry, digit carry, zero
module bmcs_alu (
  input  logic [3:0] grp,
  input  logic [7:0] m,
  input  logic [7:0] w,
  input  logic       c_in,
  output logic [7:0] r,
  output logic       c_out,
  output logic       c_upd,
  output logic       dc_out,
  output logic       dc_upd,
  output logic       z_upd
);
  logic [8:0] sum;
  logic [4:0] nib;

  always_comb begin
    sum    = {1'b0, m} + {1'b0, w};
    nib    = {1'b0, m[3:0]} + {1'b0, w[3:0]};
    r      = 8'h00;
    c_out  = 1'b0;
    c_upd  = 1'b0;
    dc_out = 1'b0;
    dc_upd = 1'b0;
    z_upd  = 1'b0;
    case (grp)
      4'h0: r = w;
      4'h1: begin r = 8'h00; z_upd = 1'b1; end
      4'h2: begin
        r = m - w; c_out = (m >= w); dc_out = (m[3:0] >= w[3:0]);
        c_upd = 1'b1; dc_upd = 1'b1; z_upd = 1'b1;
      end
      4'h3: begin r = m - 8'd1; z_upd = 1'b1; end
      4'h4: begin r = m | w; z_upd = 1'b1; end
      4'h5: begin r = m & w; z_upd = 1'b1; end
      4'h6: begin r = m ^ w; z_upd = 1'b1; end
      4'h7: begin
        r = sum[7:0]; c_out = sum[8]; dc_out = nib[4];
        c_upd = 1'b1; dc_upd = 1'b1; z_upd = 1'b1;
      end
      4'h8: begin r = m; z_upd = 1'b1; end
      4'h9: begin r = ~m; z_upd = 1'b1; end
      4'ha: begin r = m + 8'd1; z_upd = 1'b1; end
      4'hb: r = m - 8'd1;
      4'hc: begin r = {c_in, m[7:1]}; c_out = m[0]; c_upd = 1'b1; end
      4'hd: begin r = {m[6:0], c_in}; c_out = m[7]; c_upd = 1'b1; end
      4'he: r = {m[3:0], m[7:4]};
      default: r = m + 8'd1;
    endcase
  end
endmodule

### hdl/bmcs_checker.sv
// port-level checker for the core step block and its bind
`include "assert_macros.svh"

module bmcs_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       dead_cycle,
  input logic       stream_bit_valid,
  input logic       stream_bit,
  input logic       stream_start,
  input logic [1:0] fault
);
  `ASSERT_NEXT(a_result_follows, clk, rst, in_valid && in_ready, out_valid, "no result")
  `ASSERT_IMPL(a_fault_quiet, clk, rst, out_valid && fault != 2'd0,
    !dead_cycle && !stream_bit_valid && !stream_start, "fault with side effect")
  `ASSERT_IMPL(a_bit_only_valid, clk, rst, out_valid && stream_bit, stream_bit_valid,
    "stream bit without valid")
  `ASSERT_IMPL(a_ready_when_free, clk, rst, !out_valid || out_ready, in_ready,
    "stalled while output free")
endmodule

bind baseline_mcu_core_step bmcs_checker u_bmcs_checker (
  .clk(clk), .rst(rst),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .dead_cycle(out_ch.dead_cycle), .stream_bit_valid(out_ch.stream_bit_valid),
  .stream_bit(out_ch.stream_bit), .stream_start(out_ch.stream_start),
  .fault(out_ch.fault)
);

### test/baseline_mcu_core_step_test.sv
// testbench for the baseline core step block: instruction programs against a predictor
module baseline_mcu_core_step_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ItemCount = 1950;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bmcs_in_if  in_ch ();
  bmcs_out_if out_ch ();

  baseline_mcu_core_step dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state: a private copy of the core
  logic [7:0] regs [bmcs_pkg::FileRegCount];
  logic [7:0] tris_q;
  logic [7:0] option_q;
  logic [7:0] w_q;
  logic       pch_q;
  logic [8:0] stack_q [bmcs_pkg::StackDepth];
  logic [7:0] pins_q;

  bmcs_pkg::result_t expected_results [$];
  int      error_count = 0;
  bit      recv_stall_on = 1'b1;

  // pins sampled into the predictor mirror what the block will see
  function automatic void core_reset();
    for (int i = 0; i < bmcs_pkg::FileRegCount; i++) regs[i] = 8'h00;
    regs[bmcs_pkg::AddrPcl]    = bmcs_pkg::PclReset;
    regs[bmcs_pkg::AddrStatus] = bmcs_pkg::StatusReset;
    regs[bmcs_pkg::AddrFsr]    = bmcs_pkg::FsrReset;
    regs[5]                    = bmcs_pkg::OscReset;
    tris_q   = bmcs_pkg::TrisReset;
    option_q = bmcs_pkg::OptionReset;
    w_q      = 8'h00;
    pch_q    = 1'b1;
    stack_q[0] = 9'd0;
    stack_q[1] = 9'd0;
    pins_q   = bmcs_pkg::TrisReset;
  endfunction

  function automatic void pc_bump();
    regs[bmcs_pkg::AddrPcl] = regs[bmcs_pkg::AddrPcl] + 8'd1;
    if (regs[bmcs_pkg::AddrPcl] == 8'h00) pch_q = ~pch_q;
  endfunction

  function automatic void flag_put(logic [7:0] mask, bit on);
    if (on) regs[bmcs_pkg::AddrStatus] = regs[bmcs_pkg::AddrStatus] | mask;
    else regs[bmcs_pkg::AddrStatus] = regs[bmcs_pkg::AddrStatus] & ~mask;
  endfunction

  // address 0 goes through FSR
  function automatic logic [4:0] file_addr(logic [4:0] f);
    return (f == bmcs_pkg::AddrIndf) ? regs[bmcs_pkg::AddrFsr][4:0] : f;
  endfunction

  function automatic logic [7:0] file_read(logic [4:0] f, logic [5:0] pins);
    logic [4:0] a;
    logic [7:0] v;
    a = file_addr(f);
    if (a == bmcs_pkg::AddrIndf) return 8'h00;
    if (a == bmcs_pkg::AddrGpio) begin
      // latch where driven, pins where tristated, bit 2 reads high when tristated
      v = 8'h08;
      v |= regs[bmcs_pkg::AddrGpio] & ~tris_q & 8'h37;
      v |= {2'b00, pins} & tris_q & 8'h33;
      v |= tris_q & 8'h04;
      return v;
    end
    return regs[a];
  endfunction

  function automatic void file_write(logic [4:0] f, logic [7:0] v);
    logic [4:0] a;
    a = file_addr(f);
    if (a == bmcs_pkg::AddrIndf) return;
    regs[a] = v;
    if (a == bmcs_pkg::AddrPcl) pch_q = 1'b0;
    if (a == bmcs_pkg::AddrGpio) pins_q = regs[bmcs_pkg::AddrGpio] | tris_q;
  endfunction

  // execute one instruction and return the result item it causes
  function automatic bmcs_pkg::result_t core_execute(logic [11:0] op, logic [5:0] pins);
    bmcs_pkg::result_t res;
    logic [4:0] f;
    bit         d, skip;
    int         dest;      // 0 none, 1 file, 2 W
    logic [8:0] m;
    logic [8:0] r;
    logic [7:0] lit, mask, mv;
    res = '0;
    res.fault = bmcs_pkg::FAULT_NONE;
    f = op[4:0];
    d = op[5];
    lit = op[7:0];
    dest = 0;
    skip = 1'b0;
    r = '0;
    if (op < 12'h040 && !op[5]) begin
      if (f == bmcs_pkg::AddrStatus || f == bmcs_pkg::AddrFsr)
        res.fault = bmcs_pkg::FAULT_UNSUP;
      else if (f == 5'd1 || f > 5'd7) res.fault = bmcs_pkg::FAULT_ILLEG;
    end
    if (res.fault == bmcs_pkg::FAULT_NONE) begin
      pc_bump();
      if (!op[11]) begin
        if (!op[10]) begin
          if (op[9:6] != 4'h0) dest = d ? 1 : 2;
          case (op[9:6])
            4'h0: begin
              if (d) begin
                r = {1'b0, w_q};
                dest = 1;
              end else if (f == 5'd2) option_q = w_q;
              else if (f == 5'd5) begin
                res.stream_bit_valid = 1'b1;
                res.stream_bit = w_q[0];
              end else if (f == 5'd6) begin
                tris_q = w_q;
                pins_q = regs[bmcs_pkg::AddrGpio] | tris_q;
              end else if (f == 5'd7) res.stream_start = 1'b1;
            end
            4'h1: begin
              r = '0;
              flag_put(8'h04, 1'b1);
            end
            4'h2: begin
              mv = file_read(f, pins);
              r = {1'b0, mv - w_q};
              flag_put(8'h01, mv >= w_q);
              flag_put(8'h02, mv[3:0] >= w_q[3:0]);
              flag_put(8'h04, r[7:0] == 0);
            end
            4'h3, 4'h8, 4'h9, 4'ha, 4'h4, 4'h5, 4'h6: begin
              mv = file_read(f, pins);
              case (op[9:6])
                4'h3: r = {1'b0, mv - 8'd1};
                4'h4: r = {1'b0, mv | w_q};
                4'h5: r = {1'b0, mv & w_q};
                4'h6: r = {1'b0, mv ^ w_q};
                4'h8: r = {1'b0, mv};
                4'h9: r = {1'b0, ~mv};
                default: r = {1'b0, mv + 8'd1};
              endcase
              flag_put(8'h04, r[7:0] == 0);
            end
            4'h7: begin
              mv = file_read(f, pins);
              r = {1'b0, mv} + {1'b0, w_q};
              flag_put(8'h01, r[8]);
              flag_put(8'h02, ({1'b0, mv[3:0]} + {1'b0, w_q[3:0]}) > 5'h0f);
              r[8] = 1'b0;
              flag_put(8'h04, r[7:0] == 0);
            end
            4'hb: begin
              r = {1'b0, file_read(f, pins) - 8'd1};
              skip = (r[7:0] == 0);
            end
            4'hc: begin
              m = {regs[bmcs_pkg::AddrStatus][0], file_read(f, pins)};
              flag_put(8'h01, m[0]);
              r = {1'b0, m[8:1]};
            end
            4'hd: begin
              m = {file_read(f, pins), regs[bmcs_pkg::AddrStatus][0]};
              flag_put(8'h01, m[8]);
              r = {1'b0, m[7:0]};
            end
            4'he: begin
              mv = file_read(f, pins);
              r = {1'b0, mv[3:0], mv[7:4]};
            end
            default: begin
              r = {1'b0, file_read(f, pins) + 8'd1};
              skip = (r[7:0] == 0);
            end
          endcase
        end else begin
          // bit operations
          mask = 8'h01 << op[7:5];
          mv = file_read(f, pins);
          case (op[9:8])
            2'd0: begin
              r = {1'b0, mv & ~mask};
              dest = 1;
            end
            2'd1: begin
              r = {1'b0, mv | mask};
              dest = 1;
            end
            2'd2: skip = (mv & mask) == 0;
            default: skip = (mv & mask) != 0;
          endcase
        end
      end else begin
        case (op[11:8])
          4'h8: begin
            res.dead_cycle = 1'b1;
            regs[bmcs_pkg::AddrPcl] = stack_q[0][7:0];
            pch_q = stack_q[0][8];
            stack_q[0] = stack_q[1];
            w_q = lit;
          end
          4'h9: begin
            res.dead_cycle = 1'b1;
            stack_q[1] = stack_q[0];
            stack_q[0] = {pch_q, regs[bmcs_pkg::AddrPcl]};
            pch_q = 1'b0;
            regs[bmcs_pkg::AddrPcl] = lit;
          end
          4'ha, 4'hb: begin
            res.dead_cycle = 1'b1;
            pch_q = op[8];
            regs[bmcs_pkg::AddrPcl] = lit;
          end
          4'hc: w_q = lit;
          4'hd: begin
            w_q = w_q | lit;
            flag_put(8'h04, w_q == 0);
          end
          4'he: begin
            w_q = w_q & lit;
            flag_put(8'h04, w_q == 0);
          end
          default: begin
            w_q = w_q ^ lit;
            flag_put(8'h04, w_q == 0);
          end
        endcase
      end
      if (skip) begin
        pc_bump();
        res.dead_cycle = 1'b1;
      end
      if (dest == 1) file_write(f, r[7:0]);
      else if (dest == 2) w_q = r[7:0];
    end
    res.next_pc      = {pch_q, regs[bmcs_pkg::AddrPcl]};
    res.pins_out     = pins_q[5:0];
    res.w_value      = w_q;
    res.status_value = regs[bmcs_pkg::AddrStatus];
    return res;
  endfunction

  // random gap: mostly short, now and then long
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // send one instruction item, predict its result when it is taken
  task automatic send_instr(logic [11:0] op, logic [5:0] pins);
    int g;
    bmcs_pkg::result_t exp_item;
    g = gap_len();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.opcode  <= op;
    in_ch.pins_in <= pins;
    do @(posedge clk); while (!in_ch.ready);
    exp_item = core_execute(op, pins);
    expected_results = {expected_results, exp_item};
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    bmcs_pkg::result_t got, exp_r;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got.next_pc          = out_ch.next_pc;
      got.dead_cycle       = out_ch.dead_cycle;
      got.pins_out         = out_ch.pins_out;
      got.w_value          = out_ch.w_value;
      got.status_value     = out_ch.status_value;
      got.stream_bit_valid = out_ch.stream_bit_valid;
      got.stream_bit       = out_ch.stream_bit;
      got.stream_start     = out_ch.stream_start;
      got.fault            = bmcs_pkg::fault_t'(out_ch.fault);
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result item %h", $time, got);
        error_count++;
      end else begin
        exp_r = expected_results.pop_front();
        if (got.next_pc !== exp_r.next_pc) begin
          $display("%0t: next_pc exp %h got %h", $time, exp_r.next_pc, got.next_pc);
          error_count++;
        end
        if (got.dead_cycle !== exp_r.dead_cycle) begin
          $display("%0t: dead_cycle exp %b got %b", $time, exp_r.dead_cycle, got.dead_cycle);
          error_count++;
        end
        if (got.pins_out !== exp_r.pins_out) begin
          $display("%0t: pins_out exp %h got %h", $time, exp_r.pins_out, got.pins_out);
          error_count++;
        end
        if (got.w_value !== exp_r.w_value) begin
          $display("%0t: w_value exp %h got %h", $time, exp_r.w_value, got.w_value);
          error_count++;
        end
        if (got.status_value !== exp_r.status_value) begin
          $display("%0t: status exp %h got %h", $time, exp_r.status_value,
                   got.status_value);
          error_count++;
        end
        if (got.stream_bit_valid !== exp_r.stream_bit_valid) begin
          $display("%0t: stream_bit_valid exp %b got %b", $time, exp_r.stream_bit_valid,
                   got.stream_bit_valid);
          error_count++;
        end
        if (got.stream_bit !== exp_r.stream_bit) begin
          $display("%0t: stream_bit exp %b got %b", $time, exp_r.stream_bit,
                   got.stream_bit);
          error_count++;
        end
        if (got.stream_start !== exp_r.stream_start) begin
          $display("%0t: stream_start exp %b got %b", $time, exp_r.stream_start,
                   got.stream_start);
          error_count++;
        end
        if (got.fault !== exp_r.fault) begin
          $display("%0t: fault exp %0d got %0d", $time, exp_r.fault, got.fault);
          error_count++;
        end
      end
    end
  end

  // receiver ready: stalls of random length, switched off for some stretches
  initial begin
    int g;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      g = recv_stall_on ? gap_len() : 0;
      if (g > 0) begin
        out_ch.ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
  end

  // directed: a sample of the instruction classes, faults, escapes, indirection, gpio
  task automatic test_directed();
    send_instr(12'h000, 6'h00);          // nop
    send_instr(12'h003, 6'h3f);          // sleep fault
    send_instr(12'h004, 6'h00);          // clrwdt fault
    send_instr(12'h001, 6'h00);          // unrecognized
    send_instr(12'h01f, 6'h3f);          // unrecognized, top of range
    send_instr(12'hcff, 6'h00);          // movlw ff
    send_instr(12'h005, 6'h00);          // stream bit
    send_instr(12'h007, 6'h00);          // stream start
    send_instr(12'h002, 6'h00);          // option
    send_instr(12'hc0a, 6'h00);
    send_instr(12'h006, 6'h00);          // tris: some pins driven
    send_instr(12'h026, 6'h15);          // movwf gpio
    send_instr(12'h206, 6'h3f);          // movf gpio,w
    send_instr(12'h0a6, 6'h2a);          // subwf gpio
    send_instr(12'h2c4, 6'h00);          // decfsz fsr,w
    send_instr(12'h020, 6'h00);          // indirect write via fsr
    send_instr(12'hc00, 6'h00);
    send_instr(12'h024, 6'h00);          // fsr = 0, indirect reads zero
    send_instr(12'h220, 6'h00);          // movf indf,f -> 0
    send_instr(12'h3e8, 6'h00);          // incfsz
    send_instr(12'h2e8, 6'h00);          // decfsz -> skip
    send_instr(12'h910, 6'h00);          // call
    send_instr(12'h912, 6'h00);          // nested call
    send_instr(12'h8ff, 6'h00);          // retlw
    send_instr(12'h8ab, 6'h00);          // retlw
    send_instr(12'ha40, 6'h00);          // goto
    send_instr(12'hb7f, 6'h00);          // goto high page
    send_instr(12'h022, 6'h00);          // movwf pcl
    send_instr(12'h5e3, 6'h00);          // bsf status
    send_instr(12'h763, 6'h00);          // btfss status
    wait_drained();
  endtask

  // random opcode, weighted toward escapes and the special file addresses
  function automatic logic [11:0] rand_opcode();
    int p;
    logic [11:0] op;
    p = $urandom_range(0, 99);
    op = 12'($urandom_range(0, 4095));
    if (p < 8) op = 12'($urandom_range(0, 63));          // escapes, faults, movwf
    else if (p < 14) op[4:0] = bmcs_pkg::AddrGpio;
    else if (p < 20) op[4:0] = bmcs_pkg::AddrIndf;
    else if (p < 24) op[4:0] = bmcs_pkg::AddrStatus;
    else if (p < 27) op[4:0] = bmcs_pkg::AddrPcl;
    return op;
  endfunction

  task automatic test_random();
    for (int i = 0; i < ItemCount; i++) begin
      if (i == ItemCount / 2) begin
        // sender waits until the block has emptied
        wait_drained();
        recv_stall_on = 1'b0;
      end
      if (i == ItemCount * 3 / 4) recv_stall_on = 1'b1;
      send_instr(rand_opcode(), 6'($urandom_range(0, 63)));
    end
  endtask

  initial begin
    in_ch.valid   <= 1'b0;
    in_ch.opcode  <= '0;
    in_ch.pins_in <= '0;
    core_reset();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random();
    wait_drained();
    repeat (10) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("baseline_mcu_core_step_test passed");
    end else begin
      $display("baseline_mcu_core_step_test failed");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("baseline_mcu_core_step_test failed");
    $finish;
  end

endmodule
